>>> rtl/i2cbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cbs_pkg;

  localparam int PERIOD_WIDTH = 12;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = PERIOD_WIDTH'(10);

  // Operation codes
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // Segment steps within an operation
  localparam logic [2:0] PH_S0 = 3'd0;
  localparam logic [2:0] PH_S1 = 3'd1;
  localparam logic [2:0] PH_S2 = 3'd2;
  localparam logic [2:0] PH_S3 = 3'd3;
  localparam logic [2:0] PH_S4 = 3'd4;
  localparam logic [2:0] PH_S5 = 3'd5;
  localparam logic [2:0] PH_S6 = 3'd6;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       last_read;
    logic       sda_sample;
  } in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       ack_seen;
    logic [7:0] read_value;
  } out_t;

  typedef struct packed {
    logic [2:0]              active_op;
    logic [2:0]              phase;
    logic [3:0]              bit_index;
    logic [7:0]              shift_byte;
    logic [PERIOD_WIDTH-1:0] delay_left;
    logic                    nack_flag;
    logic                    scl_line;
    logic                    sda_line;
    logic                    ack_flag;
    logic [7:0]              read_value;
  } seq_st_t;

  // Idle with both lines released
  localparam seq_st_t SEQ_RESET = '{scl_line: 1'b1, sda_line: 1'b1, default: '0};

endpackage

>>> rtl/i2c_master_bit_sequencer_unit.sv
// Top level of the tick-driven open-drain I2C master bit sequencer.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_req): one request per tick. A
//    request carries an operation (tick only, start+address, write, read,
//    stop), the byte to send, the NACK choice for a read and the sampled SDA.
//  - Result channel (out_valid / out_stall / out_res): exactly one result per
//    request, giving the SCL/SDA release levels after that tick, busy, done,
//    the last ACK seen and the last byte read.
//  - Config port: cfg_wr_en / cfg_wr_data write clock_period (ticks per
//    phase delay). Write it only while no request is in flight.
// Timing:
//  - A request passes through the input register, then the result register.
//  - Throughput is one request per cycle while out_stall is low; the sequencer state updates in
//    the same single pass that fills the result register.
// Reset (rst_n low, synchronous): idle, both lines released, clock_period
//  back to 10, ack and read byte cleared, both stages empty.
// Stall: when out_stall holds a waiting result, the input register still
//  fills once; in_stall rises only when both stages are full.
module i2c_master_bit_sequencer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  i2cbs_pkg::in_t                      in_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output i2cbs_pkg::out_t                     out_res,
  input  logic                                cfg_wr_en,
  input  logic [i2cbs_pkg::PERIOD_WIDTH-1:0]  cfg_wr_data
);
  import i2cbs_pkg::*;

  logic                    in_valid_r;
  in_t                     in_req_r;
  logic                    out_valid_r;
  out_t                    out_res_r;
  seq_st_t                 st_r;
  seq_st_t                 st_nxt;
  out_t                    res_nxt;
  logic [PERIOD_WIDTH-1:0] clock_period_r;
  logic                    advance;
  logic                    in_take;

  // Result register can take a new value when empty or being drained.
  assign advance  = ~out_valid_r | ~out_stall;
  assign in_stall = in_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  i2cbs_step u_step (
    .st           (st_r),
    .req          (in_req_r),
    .clock_period (clock_period_r),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      clock_period_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req_r <= in_req;
    end
  end

  // Sequencer state and result register, updated when a request moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= SEQ_RESET;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> rtl/i2cbs_step.sv
// Next-state and result logic for one tick of the bit sequencer.
module i2cbs_step (
  input  i2cbs_pkg::seq_st_t                    st,
  input  i2cbs_pkg::in_t                        req,
  input  logic [i2cbs_pkg::PERIOD_WIDTH-1:0]    clock_period,
  output i2cbs_pkg::seq_st_t                    st_nxt,
  output i2cbs_pkg::out_t                       res
);
  import i2cbs_pkg::*;

  logic                    run;
  logic                    done;
  logic [PERIOD_WIDTH-1:0] half;
  logic [3:0]              bit_inc;
  logic [2:0]              sel;

  assign half = clock_period >> 1;

  always_comb begin
    st_nxt  = st;
    run     = 1'b0;
    done    = 1'b0;
    bit_inc = 4'd0;
    sel     = 3'd0;

    if (st.active_op == OP_IDLE) begin
      if (req.operation == OP_START || req.operation == OP_WRITE ||
          req.operation == OP_READ  || req.operation == OP_STOP) begin
        st_nxt.active_op  = req.operation;
        st_nxt.phase      = (req.operation == OP_WRITE) ? PH_S1 : PH_S0;
        st_nxt.bit_index  = 4'd0;
        st_nxt.shift_byte = (req.operation == OP_READ) ? 8'd0 : req.data_byte;
        st_nxt.nack_flag  = req.last_read;
        st_nxt.delay_left = '0;
        run               = 1'b1;
      end
    end else if (st.delay_left != '0) begin
      st_nxt.delay_left = st.delay_left - PERIOD_WIDTH'(1);
    end else begin
      run = 1'b1;
    end

    if (run) begin
      bit_inc = st_nxt.bit_index + 4'd1;
      sel     = 3'd7 - st_nxt.bit_index[2:0];
      if (st_nxt.active_op == OP_START || st_nxt.active_op == OP_WRITE) begin
        unique case (st_nxt.phase)
          PH_S0: begin
            st_nxt.sda_line   = 1'b0;
            st_nxt.delay_left = clock_period;
            st_nxt.phase      = PH_S1;
          end
          PH_S1: begin
            st_nxt.scl_line = 1'b0;
            st_nxt.sda_line = st_nxt.shift_byte[sel];
            st_nxt.phase    = PH_S2;
          end
          PH_S2: begin
            st_nxt.scl_line   = 1'b1;
            st_nxt.delay_left = clock_period;
            st_nxt.bit_index  = bit_inc;
            st_nxt.phase      = (bit_inc >= BITS_PER_BYTE) ? PH_S3 : PH_S1;
          end
          PH_S3: begin
            st_nxt.scl_line = 1'b0;
            st_nxt.sda_line = 1'b1;
            st_nxt.phase    = PH_S4;
          end
          PH_S4: begin
            st_nxt.scl_line   = 1'b1;
            st_nxt.delay_left = half;
            st_nxt.phase      = PH_S5;
          end
          PH_S5: begin
            st_nxt.ack_flag   = ~req.sda_sample;
            st_nxt.scl_line   = 1'b0;
            st_nxt.delay_left = half;
            st_nxt.phase      = PH_S6;
          end
          default: begin
            st_nxt.sda_line = 1'b0;
            done            = 1'b1;
          end
        endcase
      end else if (st_nxt.active_op == OP_READ) begin
        unique case (st_nxt.phase)
          PH_S0: begin
            st_nxt.sda_line   = 1'b1;
            st_nxt.delay_left = clock_period;
            st_nxt.phase      = PH_S1;
          end
          PH_S1: begin
            st_nxt.scl_line = 1'b1;
            st_nxt.phase    = PH_S2;
          end
          PH_S2: begin
            st_nxt.shift_byte = {st_nxt.shift_byte[6:0], req.sda_sample};
            st_nxt.scl_line   = 1'b0;
            st_nxt.delay_left = clock_period;
            st_nxt.bit_index  = bit_inc;
            st_nxt.phase      = (bit_inc >= BITS_PER_BYTE) ? PH_S3 : PH_S1;
          end
          PH_S3: begin
            st_nxt.sda_line = st_nxt.nack_flag;
            st_nxt.phase    = PH_S4;
          end
          PH_S4: begin
            st_nxt.scl_line   = 1'b1;
            st_nxt.delay_left = clock_period;
            st_nxt.phase      = PH_S5;
          end
          PH_S5: begin
            st_nxt.scl_line   = 1'b0;
            st_nxt.delay_left = clock_period;
            st_nxt.phase      = PH_S6;
          end
          default: begin
            st_nxt.sda_line   = 1'b0;
            st_nxt.read_value = st_nxt.shift_byte;
            done              = 1'b1;
          end
        endcase
      end else if (st_nxt.active_op == OP_STOP) begin
        unique case (st_nxt.phase)
          PH_S0: begin
            st_nxt.sda_line   = 1'b0;
            st_nxt.delay_left = clock_period;
            st_nxt.phase      = PH_S1;
          end
          PH_S1: begin
            st_nxt.scl_line   = 1'b1;
            st_nxt.delay_left = clock_period;
            st_nxt.phase      = PH_S2;
          end
          PH_S2: begin
            st_nxt.sda_line   = 1'b1;
            st_nxt.delay_left = clock_period;
            st_nxt.phase      = PH_S3;
          end
          default: done = 1'b1;
        endcase
      end else begin
        done = 1'b1;
      end
    end

    if (done) begin
      st_nxt.active_op  = OP_IDLE;
      st_nxt.phase      = PH_S0;
      st_nxt.bit_index  = 4'd0;
      st_nxt.delay_left = '0;
    end
  end

  assign res.scl_release = st_nxt.scl_line;
  assign res.sda_release = st_nxt.sda_line;
  assign res.busy_res    = (st_nxt.active_op != OP_IDLE);
  assign res.done_res    = done;
  assign res.ack_seen    = st_nxt.ack_flag;
  assign res.read_value  = st_nxt.read_value;

endmodule
